// ===== rtl/gsc_pkg.sv =====
`default_nettype none

package gsc_pkg;

    localparam int PADDR_W    = 4;
    localparam int U_W        = 25;   // gained magnitude, Q.24, up to 1.0 inclusive
    localparam int S_W        = 25;   // u*u >> 24
    localparam int T1_W       = 29;   // 27 + s
    localparam int T2_W       = 30;   // 27 + 9s, also the divisor
    localparam int NUM_W      = 54;   // u * (27 + s)
    localparam int DIVIDEND_W = 46;
    localparam int Q_W        = 16;
    localparam int DIV_STAGES = Q_W;  // one quotient bit per stage

    localparam logic [15:0]         VOL_MAX    = 16'd32768;
    localparam logic [55:0]         UNITY_Q46  = 56'd1 << 46;
    localparam logic [T2_W-1:0]     C27_Q24    = T2_W'(27) << 24;
    localparam logic [Q_W-1:0]      FULL_SCALE = 16'd32767;

    typedef struct packed {
        logic signed [23:0] mix_sample;
        logic               block_end;
    } in_word_t;

    typedef struct packed {
        logic signed [15:0] out_sample;
        logic               block_end_out;
    } out_word_t;

    typedef struct packed {
        logic [15:0] master_volume;
        logic [15:0] normalize_gain;
        logic        normalize_enable;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        master_volume:    16'd16384,
        normalize_gain:   16'd23170,
        normalize_enable: 1'b1
    };

    // sideband carried with every sample through the pipe
    typedef struct packed {
        logic neg;
        logic clip;
        logic block_end;
    } side_t;

endpackage

`default_nettype wire

// ===== rtl/gsc_cfg.sv =====
`default_nettype none

module gsc_cfg
    import gsc_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    output logic      [31:0]        prdata,
    output cfg_t                    cfg
);

    localparam logic [1:0] REG_MASTER_VOLUME    = 2'd0;
    localparam logic [1:0] REG_NORMALIZE_GAIN   = 2'd1;
    localparam logic [1:0] REG_NORMALIZE_ENABLE = 2'd2;

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else if (wr_en) begin
            case (reg_idx)
                REG_MASTER_VOLUME: begin
                    // out-of-range volume is dropped
                    if (pwdata[15:0] <= VOL_MAX) begin
                        cfg_reg.master_volume <= pwdata[15:0];
                    end
                end
                REG_NORMALIZE_GAIN:   cfg_reg.normalize_gain   <= pwdata[15:0];
                REG_NORMALIZE_ENABLE: cfg_reg.normalize_enable <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_MASTER_VOLUME:    prdata = {16'd0, cfg_reg.master_volume};
            REG_NORMALIZE_GAIN:   prdata = {16'd0, cfg_reg.normalize_gain};
            REG_NORMALIZE_ENABLE: prdata = {31'd0, cfg_reg.normalize_enable};
            default:              prdata = 32'd0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== rtl/gsc_gain.sv =====
`default_nettype none

module gsc_gain
    import gsc_pkg::*;
(
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           advance,
    input  wire logic           in_valid,
    input  wire in_word_t       in_word,
    input  wire cfg_t           cfg,
    output logic                out_valid,
    output logic    [U_W-1:0]   out_u,
    output side_t               out_side
);

    // stage 1: magnitude times volume
    logic        v1_reg;
    logic [39:0] p1_reg;
    side_t       side1_reg;
    // stage 2: times normalization gain (or shifted left by 12 when it is off), Q.46
    logic        v2_reg;
    logic [55:0] a_reg;
    side_t       side2_reg;
    // stage 3: clip detect and truncate to Q.24
    logic           v3_reg;
    logic [U_W-1:0] u_reg;
    side_t          side3_reg;

    logic        neg;
    logic [23:0] mag;
    logic [39:0] p1_next;
    logic [55:0] a_next;
    logic        clip_next;

    assign neg     = in_word.mix_sample[23];
    assign mag     = neg ? (~in_word.mix_sample + 24'd1) : in_word.mix_sample;
    assign p1_next = 40'(mag) * 40'(cfg.master_volume);
    assign a_next  = cfg.normalize_enable ? (56'(p1_reg) * 56'(cfg.normalize_gain))
                                          : {4'd0, p1_reg, 12'd0};
    assign clip_next = a_reg > UNITY_Q46;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (advance) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            p1_reg    <= p1_next;
            side1_reg <= '{neg: neg, clip: 1'b0, block_end: in_word.block_end};
            a_reg     <= a_next;
            side2_reg <= side1_reg;
            u_reg     <= a_reg[46:22];
            side3_reg <= '{neg: side2_reg.neg, clip: clip_next,
                           block_end: side2_reg.block_end};
        end
    end

    assign out_valid = v3_reg;
    assign out_u     = u_reg;
    assign out_side  = side3_reg;

endmodule

`default_nettype wire

// ===== rtl/gsc_pade.sv =====
`default_nettype none

module gsc_pade
    import gsc_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  advance,
    input  wire logic                  in_valid,
    input  wire logic [U_W-1:0]        in_u,
    input  wire side_t                 in_side,
    output logic                       out_valid,
    output logic      [DIVIDEND_W-1:0] out_dividend,
    output logic      [T2_W-1:0]       out_divisor,
    output side_t                      out_side
);

    // stage 4: square
    logic           v4_reg;
    logic [49:0]    sq_reg;
    logic [U_W-1:0] u4_reg;
    side_t          side4_reg;
    // stage 5: numerator and denominator polynomials
    logic            v5_reg;
    logic [T1_W-1:0] t1_reg;
    logic [T2_W-1:0] t2_reg;
    logic [U_W-1:0]  u5_reg;
    side_t           side5_reg;
    // stage 6: numerator product
    logic            v6_reg;
    logic [NUM_W-1:0] num_reg;
    logic [T2_W-1:0] dd6_reg;
    side_t           side6_reg;
    // stage 7: rounding bias, fold the 2^9 into the dividend
    logic                  v7_reg;
    logic [DIVIDEND_W-1:0] dividend_reg;
    logic [T2_W-1:0]       dd7_reg;
    side_t                 side7_reg;

    logic [S_W-1:0]   s;
    logic [T1_W-1:0]  t1_next;
    logic [T2_W-1:0]  t2_next;
    logic [54:0]      biased;

    assign s       = sq_reg[48:24];
    assign t1_next = T1_W'(C27_Q24) + T1_W'(s);
    assign t2_next = C27_Q24 + T2_W'(s) + {2'd0, s, 3'd0};
    // floor((num + den/2) / (dd*2^9)) == floor(floor((num + dd*2^8) / 2^9) / dd)
    assign biased  = 55'(num_reg) + {17'd0, dd6_reg, 8'd0};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end else if (advance) begin
            v4_reg <= in_valid;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            sq_reg       <= 50'(in_u) * 50'(in_u);
            u4_reg       <= in_u;
            side4_reg    <= in_side;
            t1_reg       <= t1_next;
            t2_reg       <= t2_next;
            u5_reg       <= u4_reg;
            side5_reg    <= side4_reg;
            num_reg      <= NUM_W'(u5_reg) * NUM_W'(t1_reg);
            dd6_reg      <= t2_reg;
            side6_reg    <= side5_reg;
            dividend_reg <= biased[54:9];
            dd7_reg      <= dd6_reg;
            side7_reg    <= side6_reg;
        end
    end

    assign out_valid    = v7_reg;
    assign out_dividend = dividend_reg;
    assign out_divisor  = dd7_reg;
    assign out_side     = side7_reg;

endmodule

`default_nettype wire

// ===== rtl/gsc_div.sv =====
`default_nettype none

module gsc_div
    import gsc_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  advance,
    input  wire logic                  in_valid,
    input  wire logic [DIVIDEND_W-1:0] in_dividend,
    input  wire logic [T2_W-1:0]       in_divisor,
    input  wire side_t                 in_side,
    output logic                       out_valid,
    output logic      [Q_W-1:0]        out_quot,
    output side_t                      out_side
);

    // restoring divider, one quotient bit per stage, MSB first
    logic                  v_reg    [1:DIV_STAGES];
    logic [DIVIDEND_W-1:0] rem_reg  [1:DIV_STAGES-1];
    logic [T2_W-1:0]       dvs_reg  [1:DIV_STAGES-1];
    logic [Q_W-1:0]        q_reg    [1:DIV_STAGES];
    side_t                 side_reg [1:DIV_STAGES];

    logic [DIVIDEND_W-1:0] rem_cur  [0:DIV_STAGES-1];
    logic [T2_W-1:0]       dvs_cur  [0:DIV_STAGES-1];
    logic [Q_W-1:0]        q_cur    [0:DIV_STAGES-1];
    logic [DIVIDEND_W-1:0] rem_next [1:DIV_STAGES];
    logic [Q_W-1:0]        q_next   [1:DIV_STAGES];

    always_comb begin
        logic [DIVIDEND_W-1:0] trial;
        rem_cur[0] = in_dividend;
        dvs_cur[0] = in_divisor;
        q_cur[0]   = '0;
        for (int k = 1; k < DIV_STAGES; k++) begin
            rem_cur[k] = rem_reg[k];
            dvs_cur[k] = dvs_reg[k];
            q_cur[k]   = q_reg[k];
        end
        for (int k = 0; k < DIV_STAGES; k++) begin
            trial      = DIVIDEND_W'(dvs_cur[k]) << (DIV_STAGES - 1 - k);
            q_next[k+1] = q_cur[k];
            if (rem_cur[k] >= trial) begin
                rem_next[k+1] = rem_cur[k] - trial;
                q_next[k+1][DIV_STAGES-1-k] = 1'b1;
            end else begin
                rem_next[k+1] = rem_cur[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 1; k <= DIV_STAGES; k++) begin
                v_reg[k] <= 1'b0;
            end
        end else if (advance) begin
            v_reg[1] <= in_valid;
            for (int k = 2; k <= DIV_STAGES; k++) begin
                v_reg[k] <= v_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            side_reg[1] <= in_side;
            for (int k = 1; k <= DIV_STAGES; k++) begin
                q_reg[k] <= q_next[k];
            end
            for (int k = 1; k < DIV_STAGES; k++) begin
                rem_reg[k] <= rem_next[k];
                dvs_reg[k] <= dvs_cur[k-1];
            end
            for (int k = 2; k <= DIV_STAGES; k++) begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    assign out_valid = v_reg[DIV_STAGES];
    assign out_quot  = q_reg[DIV_STAGES];
    assign out_side  = side_reg[DIV_STAGES];

endmodule

`default_nettype wire

// ===== rtl/gain_and_soft_clip_mixer_output.sv =====
// Pipeline: an accepted word passes 3 gain stages, 4 polynomial stages, 16 divider stages
//   and 1 output register before its result word is presented on m_valid.
// Throughput: one word per cycle; the 16-stage divider is fully pipelined.
//   m_ready low with a word held at the output freezes every stage.
// Reset: synchronous, active low; clears all valid bits and loads the register defaults.
`default_nettype none

module gain_and_soft_clip_mixer_output
    import gsc_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire in_word_t           s_word,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output out_word_t               m_word,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    output logic      [31:0]        prdata,
    output logic                    pready
);

    cfg_t                  cfg;
    logic                  advance;

    logic                  g_valid;
    logic [U_W-1:0]        g_u;
    side_t                 g_side;

    logic                  p_valid;
    logic [DIVIDEND_W-1:0] p_dividend;
    logic [T2_W-1:0]       p_divisor;
    side_t                 p_side;

    logic                  d_valid;
    logic [Q_W-1:0]        d_quot;
    side_t                 d_side;

    logic                  m_valid_reg;
    out_word_t             m_word_reg;
    out_word_t             m_word_next;
    logic [Q_W-1:0]        mag_y;

    assign advance = !m_valid_reg || m_ready;
    assign s_ready = advance;
    assign pready  = 1'b1;

    gsc_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    gsc_gain u_gain (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .in_valid  (s_valid),
        .in_word   (s_word),
        .cfg       (cfg),
        .out_valid (g_valid),
        .out_u     (g_u),
        .out_side  (g_side)
    );

    gsc_pade u_pade (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .advance      (advance),
        .in_valid     (g_valid),
        .in_u         (g_u),
        .in_side      (g_side),
        .out_valid    (p_valid),
        .out_dividend (p_dividend),
        .out_divisor  (p_divisor),
        .out_side     (p_side)
    );

    gsc_div u_div (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .advance     (advance),
        .in_valid    (p_valid),
        .in_dividend (p_dividend),
        .in_divisor  (p_divisor),
        .in_side     (p_side),
        .out_valid   (d_valid),
        .out_quot    (d_quot),
        .out_side    (d_side)
    );

    assign mag_y = d_side.clip ? FULL_SCALE : d_quot;

    always_comb begin
        m_word_next.out_sample    = d_side.neg ? signed'(~mag_y + 16'd1) : signed'(mag_y);
        m_word_next.block_end_out = d_side.block_end;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= d_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_word_reg <= m_word_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_word  = m_word_reg;

`ifndef ASSERT_OFF
    a_no_neg_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_word.out_sample != 16'sh8000)
        else $error("output word reached -32768");

    a_quot_range: assert property (@(posedge aclk) disable iff (!aresetn)
        d_valid && !d_side.clip |-> !d_quot[Q_W-1])
        else $error("soft-clip quotient above full scale");

    a_vol_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg.master_volume <= VOL_MAX)
        else $error("master volume above 2.0");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");
`endif

endmodule

`default_nettype wire

// ===== sim/gain_and_soft_clip_mixer_output_tb.sv =====
`default_nettype none

module gain_and_soft_clip_mixer_output_tb;
    import gsc_pkg::*;

    localparam int QUIET_LIMIT   = 2000;
    localparam int PIPE_SETTLE   = 32;
    localparam int SEGMENTS      = 6;
    localparam int SEGMENT_WORDS = 190;
    localparam int DIRECTED_ROWS = 19;
    localparam int CFG_WRITES    = 17;

    localparam logic [63:0] UNITY_MAG    = 64'd1 << 46;
    localparam logic [63:0] PADE_K27     = 64'd27 << 24;
    localparam logic [15:0] VOLUME_LIMIT = 16'd32768;
    localparam logic [15:0] CLIP_LEVEL   = 16'd32767;

    typedef enum logic [1:0] {
        REG_MASTER_VOLUME,
        REG_NORMALIZE_GAIN,
        REG_NORMALIZE_ENABLE,
        REG_UNMAPPED
    } reg_index_t;

    typedef struct packed {
        logic signed [23:0] mix;
        logic               blk;
        logic               bypass;
        logic               typed;
        logic signed [15:0] want;
    } vector_t;

    typedef struct packed {
        logic [2:0]  seg;
        reg_index_t  idx;
        logic [31:0] data;
    } reg_write_t;

    // rows with bypass set run with normalization switched off
    localparam vector_t DIRECTED [DIRECTED_ROWS] = '{
        '{24'sd0,        1'b0, 1'b0, 1'b1, 16'sd0},
        '{24'sd0,        1'b1, 1'b0, 1'b1, 16'sd0},
        '{24'sd8388607,  1'b0, 1'b0, 1'b1, 16'sd32767},
        '{-24'sd8388608, 1'b1, 1'b0, 1'b1, -16'sd32767},
        '{24'sd1,        1'b0, 1'b0, 1'b0, 16'sd0},
        '{-24'sd1,       1'b0, 1'b0, 1'b0, 16'sd0},
        '{24'sd100000,   1'b0, 1'b0, 1'b0, 16'sd0},
        '{-24'sd100000,  1'b1, 1'b0, 1'b0, 16'sd0},
        '{24'sd185367,   1'b0, 1'b0, 1'b0, 16'sd0},
        '{-24'sd185368,  1'b0, 1'b0, 1'b0, 16'sd0},
        '{24'sd1048576,  1'b0, 1'b1, 1'b1, 16'sd25486},
        '{-24'sd1048576, 1'b1, 1'b1, 1'b1, -16'sd25486},
        '{24'sd1048577,  1'b0, 1'b1, 1'b1, 16'sd32767},
        '{-24'sd1048577, 1'b0, 1'b1, 1'b1, -16'sd32767},
        '{24'sd1048575,  1'b0, 1'b1, 1'b0, 16'sd0},
        '{24'sd524288,   1'b0, 1'b1, 1'b0, 16'sd0},
        '{-24'sd524288,  1'b1, 1'b1, 1'b0, 16'sd0},
        '{24'sd8388607,  1'b0, 1'b1, 1'b1, 16'sd32767},
        '{24'sd0,        1'b1, 1'b1, 1'b1, 16'sd0}
    };

    // register settings applied ahead of each random segment
    localparam reg_write_t SEGMENT_CFG [CFG_WRITES] = '{
        '{3'd0, REG_MASTER_VOLUME,    32'd32768},
        '{3'd0, REG_NORMALIZE_GAIN,   32'd65535},
        '{3'd0, REG_NORMALIZE_ENABLE, 32'd1},
        '{3'd1, REG_MASTER_VOLUME,    32'd0},
        '{3'd1, REG_MASTER_VOLUME,    32'd32769},      // above limit, dropped
        '{3'd1, REG_UNMAPPED,         32'h0000_1234},
        '{3'd2, REG_MASTER_VOLUME,    32'd16384},
        '{3'd2, REG_NORMALIZE_GAIN,   32'd0},
        '{3'd2, REG_NORMALIZE_ENABLE, 32'hFFFF_FFFE},  // masks to 0
        '{3'd3, REG_MASTER_VOLUME,    32'hABCD_4E20},
        '{3'd3, REG_NORMALIZE_GAIN,   32'd4096},
        '{3'd3, REG_NORMALIZE_ENABLE, 32'd1},
        '{3'd4, REG_MASTER_VOLUME,    32'hFFFF_0001},
        '{3'd4, REG_MASTER_VOLUME,    32'h0000_FFFF},  // above limit, dropped
        '{3'd4, REG_NORMALIZE_GAIN,   32'h5555_AAAA},
        '{3'd5, REG_MASTER_VOLUME,    32'd8192},
        '{3'd5, REG_NORMALIZE_ENABLE, 32'd0}
    };

    logic                aclk;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    in_word_t            s_word  = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    out_word_t           m_word;
    logic                psel    = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite  = 1'b0;
    logic [PADDR_W-1:0]  paddr   = '0;
    logic [31:0]         pwdata  = '0;
    logic [31:0]         prdata;
    logic                pready;

    cfg_t      shadow_cfg  = CFG_RESET;
    out_word_t word_expect = '0;
    out_word_t clip_expect_q[$];
    int        sent_count     = 0;
    int        recv_count     = 0;
    int        error_count    = 0;
    int        quiet_cycles   = 0;
    int        send_idle_pct  = 0;
    int        recv_stall_pct = 0;

    gain_and_soft_clip_mixer_output uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_word  (s_word),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_word  (m_word),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // gain, hard limit above unity, else Pade tanh on the magnitude
    function automatic out_word_t soft_clip_predict(input in_word_t w, input cfg_t c);
        logic [23:0] mag;
        logic [63:0] gained, u, s, num, den, y;
        out_word_t   r;
        mag    = w.mix_sample[23] ? (~w.mix_sample + 24'd1) : w.mix_sample;
        gained = 64'(mag) * 64'(c.master_volume);
        gained = c.normalize_enable ? gained * 64'(c.normalize_gain) : gained << 12;
        if (gained > UNITY_MAG) begin
            y = 64'(CLIP_LEVEL);
        end else begin
            u   = gained >> 22;
            s   = (u * u) >> 24;
            num = u * (PADE_K27 + s);
            den = (PADE_K27 + 64'd9 * s) << 9;
            y   = (num + den / 64'd2) / den;
        end
        r.out_sample    = w.mix_sample[23] ? 16'(-y) : 16'(y);
        r.block_end_out = w.block_end;
        return r;
    endfunction

    task automatic send_word(input in_word_t w, input out_word_t e);
        while (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_word      <= w;
        word_expect <= e;
        do @(posedge aclk); while (!s_ready);
        sent_count++;
    endtask

    task automatic drain_pipe();
        s_valid <= 1'b0;
        while (recv_count != sent_count) @(posedge aclk);
        repeat (PIPE_SETTLE) @(posedge aclk);
    endtask

    // leaves the bus selected; caller releases it after the last write
    task automatic apb_write(input reg_index_t idx, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        case (idx)
            REG_MASTER_VOLUME: begin
                if (data[15:0] <= VOLUME_LIMIT)
                    shadow_cfg.master_volume = data[15:0];
            end
            REG_NORMALIZE_GAIN:   shadow_cfg.normalize_gain   = data[15:0];
            REG_NORMALIZE_ENABLE: shadow_cfg.normalize_enable = data[0];
            default: ;
        endcase
    endtask

    always @(posedge aclk) begin
        m_ready <= (recv_stall_pct == 0) || ($urandom_range(99, 0) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        out_word_t want;
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (s_valid && s_ready)
                clip_expect_q.push_back(word_expect);
            if (m_valid && m_ready) begin
                recv_count <= recv_count + 1;
                if (clip_expect_q.size() == 0) begin
                    error_count++;
                    if (error_count <= 10)
                        $display("unexpected word: %0d/%0b",
                                 m_word.out_sample, m_word.block_end_out);
                end else begin
                    want = clip_expect_q.pop_front();
                    if (m_word.out_sample !== want.out_sample ||
                        m_word.block_end_out !== want.block_end_out) begin
                        error_count++;
                        if (error_count <= 10)
                            $display("mismatch: expected %0d/%0b got %0d/%0b",
                                     want.out_sample, want.block_end_out,
                                     m_word.out_sample, m_word.block_end_out);
                    end
                end
            end
        end
    end

    initial begin
        while (quiet_cycles < QUIET_LIMIT) @(posedge aclk);
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        in_word_t    w;
        out_word_t   e;
        vector_t     row;
        logic [31:0] mag, raw;
        int          seg, n, k;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (n = 0; n < DIRECTED_ROWS; n++) begin
            row = DIRECTED[n];
            if (row.bypass == shadow_cfg.normalize_enable) begin
                drain_pipe();
                apb_write(REG_NORMALIZE_ENABLE, {31'd0, ~row.bypass});
                psel    <= 1'b0;
                penable <= 1'b0;
            end
            w.mix_sample = row.mix;
            w.block_end  = row.blk;
            e = soft_clip_predict(w, shadow_cfg);
            if (row.typed)
                e.out_sample = row.want;
            send_word(w, e);
        end

        for (seg = 0; seg < SEGMENTS; seg++) begin
            drain_pipe();
            for (k = 0; k < CFG_WRITES; k++)
                if (SEGMENT_CFG[k].seg == seg)
                    apb_write(SEGMENT_CFG[k].idx, SEGMENT_CFG[k].data);
            psel    <= 1'b0;
            penable <= 1'b0;
            send_idle_pct  = (seg < 2) ? 19 : (seg < 4) ? 48 : 0;
            recv_stall_pct = (seg < 2) ? 48 : (seg < 4) ? 19 : 0;
            for (n = 0; n < SEGMENT_WORDS; n++) begin
                // log-spread magnitudes reach both the curve and the limiter
                if ($urandom_range(3, 0) == 0) begin
                    raw = $urandom;
                end else begin
                    mag = $urandom & ((32'd1 << $urandom_range(23, 0)) - 32'd1);
                    raw = $urandom_range(1, 0) ? -mag : mag;
                end
                w.mix_sample = raw[23:0];
                w.block_end  = ($urandom_range(7, 0) == 0);
                send_word(w, soft_clip_predict(w, shadow_cfg));
            end
        end

        drain_pipe();
        if (clip_expect_q.size() != 0) begin
            error_count += clip_expect_q.size();
            $display("%0d words never arrived", clip_expect_q.size());
        end
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire
